// ===== design/bsc_pkg.sv =====
// Package for the barometric compensation core: widths, latency and shared types.
// Used by bsc_front, bsc_div, bsc_back and baro_sensor_compensation_core.
package bsc_pkg;

    localparam int RAW_W        = 20;
    localparam int DATA_W       = 32;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int FRONT_STAGES = 11;
    localparam int BACK_STAGES  = 4;
    localparam int LATENCY      = FRONT_STAGES + DATA_W + BACK_STAGES;

    localparam logic [CFG_IDX_W-1:0] REG_CAL_TEMP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_PRESS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_PRESS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_P9      = 2'd3;

    localparam logic [DATA_W-1:0] OFS_64000   = 32'd64000;
    localparam logic [DATA_W-1:0] OFS_1048576 = 32'd1048576;
    localparam logic [DATA_W-1:0] K_3125      = 32'd3125;
    localparam logic [DATA_W-1:0] OFS_32768   = 32'd32768;
    localparam logic [DATA_W-1:0] RND_128     = 32'd128;

    // calibration words, sign- or zero-extended to 32 bits
    typedef struct packed {
        logic [DATA_W-1:0] t1;
        logic [DATA_W-1:0] t2;
        logic [DATA_W-1:0] t3;
        logic [DATA_W-1:0] p1;
        logic [DATA_W-1:0] p2;
        logic [DATA_W-1:0] p3;
        logic [DATA_W-1:0] p4;
        logic [DATA_W-1:0] p5;
        logic [DATA_W-1:0] p6;
        logic [DATA_W-1:0] p7;
        logic [DATA_W-1:0] p8;
        logic [DATA_W-1:0] p9;
    } cal_t;

    // carried alongside the division
    typedef struct packed {
        logic [DATA_W-1:0] temp;
        logic              post2;
        logic              zero;
    } side_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
        side_t             side;
    } div_req_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] quotient;
        side_t             side;
    } div_rsp_t;

    function automatic logic [DATA_W-1:0] sra(input logic [DATA_W-1:0] x, input int n);
        sra = DATA_W'($signed(x) >>> n);
    endfunction

endpackage

// ===== design/bsc_front.sv =====
// Front pipeline: fine temperature, compensated temperature, divisor and dividend.
// Depends on bsc_pkg.
module bsc_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [bsc_pkg::RAW_W-1:0]      adc_t,
    input  logic [bsc_pkg::RAW_W-1:0]      adc_p,
    input  bsc_pkg::cal_t                  cal,
    output bsc_pkg::div_req_t              req
);

    localparam int W = bsc_pkg::DATA_W;

    logic [bsc_pkg::FRONT_STAGES:1] v_reg;

    logic [W-1:0] ain_reg, d_reg, ap1_reg, ap2_reg, ap3_reg, ap4_reg, ap5_reg;
    logic [W-1:0] ap6_reg, ap7_reg, ap8_reg;
    logic [W-1:0] ma_reg, dd_reg;
    logic [W-1:0] a3_reg, b1_reg;
    logic [W-1:0] tf_reg;
    logic [W-1:0] temp5_reg, temp6_reg, temp7_reg, temp8_reg, temp9_reg, temp10_reg;
    logic [W-1:0] v1_reg, q_reg;
    logic [W-1:0] qq_reg, v1p5_reg, p2v1_reg;
    logic [W-1:0] v2a_reg, t13_reg, v1p5b_reg, p2v1b_reg;
    logic [W-1:0] v2_reg, v1c_reg;
    logic [W-1:0] v1d_reg, pre_reg;
    logic [W-1:0] dvs_reg, pn_reg;
    logic [W-1:0] dvs11_reg, dvd_reg, temp11_reg;
    logic         post2_reg, zero_reg;

    logic [W-1:0] adc_t32, adc_p32, tf5, v2b;

    assign adc_t32 = W'(adc_t);
    assign adc_p32 = W'(adc_p);
    assign tf5     = (tf_reg << 2) + tf_reg + bsc_pkg::RND_128;
    assign v2b     = v2a_reg + (v1p5b_reg << 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[bsc_pkg::FRONT_STAGES-1:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1
        ain_reg    <= (adc_t32 >> 3) - (cal.t1 << 1);
        d_reg      <= (adc_t32 >> 4) - cal.t1;
        ap1_reg    <= adc_p32;
        // stage 2
        ma_reg     <= ain_reg * cal.t2;
        dd_reg     <= d_reg * d_reg;
        ap2_reg    <= ap1_reg;
        // stage 3
        a3_reg     <= bsc_pkg::sra(ma_reg, 11);
        b1_reg     <= bsc_pkg::sra(dd_reg, 12) * cal.t3;
        ap3_reg    <= ap2_reg;
        // stage 4
        tf_reg     <= a3_reg + bsc_pkg::sra(b1_reg, 14);
        ap4_reg    <= ap3_reg;
        // stage 5
        temp5_reg  <= bsc_pkg::sra(tf5, 8);
        v1_reg     <= bsc_pkg::sra(tf_reg, 1) - bsc_pkg::OFS_64000;
        q_reg      <= bsc_pkg::sra(bsc_pkg::sra(tf_reg, 1) - bsc_pkg::OFS_64000, 2);
        ap5_reg    <= ap4_reg;
        // stage 6
        qq_reg     <= q_reg * q_reg;
        v1p5_reg   <= v1_reg * cal.p5;
        p2v1_reg   <= cal.p2 * v1_reg;
        temp6_reg  <= temp5_reg;
        ap6_reg    <= ap5_reg;
        // stage 7
        v2a_reg    <= bsc_pkg::sra(qq_reg, 11) * cal.p6;
        t13_reg    <= cal.p3 * bsc_pkg::sra(qq_reg, 13);
        v1p5b_reg  <= v1p5_reg;
        p2v1b_reg  <= p2v1_reg;
        temp7_reg  <= temp6_reg;
        ap7_reg    <= ap6_reg;
        // stage 8
        v2_reg     <= bsc_pkg::sra(v2b, 2) + (cal.p4 << 16);
        v1c_reg    <= bsc_pkg::sra(bsc_pkg::sra(t13_reg, 3) + bsc_pkg::sra(p2v1b_reg, 1), 18);
        temp8_reg  <= temp7_reg;
        ap8_reg    <= ap7_reg;
        // stage 9
        v1d_reg    <= (bsc_pkg::OFS_32768 + v1c_reg) * cal.p1;
        pre_reg    <= (bsc_pkg::OFS_1048576 - ap8_reg) - bsc_pkg::sra(v2_reg, 12);
        temp9_reg  <= temp8_reg;
        // stage 10
        dvs_reg    <= bsc_pkg::sra(v1d_reg, 15);
        pn_reg     <= pre_reg * bsc_pkg::K_3125;
        temp10_reg <= temp9_reg;
        // stage 11
        dvs11_reg  <= dvs_reg;
        zero_reg   <= (dvs_reg == '0);
        post2_reg  <= pn_reg[W-1];
        dvd_reg    <= pn_reg[W-1] ? pn_reg : (pn_reg << 1);
        temp11_reg <= temp10_reg;
    end

    assign req.valid      = v_reg[bsc_pkg::FRONT_STAGES];
    assign req.dividend   = dvd_reg;
    assign req.divisor    = dvs11_reg;
    assign req.side.temp  = temp11_reg;
    assign req.side.post2 = post2_reg;
    assign req.side.zero  = zero_reg;

endmodule

// ===== design/bsc_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Depends on bsc_pkg.
module bsc_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  bsc_pkg::div_req_t req,
    output bsc_pkg::div_rsp_t rsp
);

    localparam int N = bsc_pkg::DATA_W;

    logic [N-1:0]         v_reg;
    logic [N-1:0]         rem_reg  [N];
    logic [N-1:0]         dvd_reg  [N];
    logic [N-1:0]         dvs_reg  [N];
    logic [N-1:0]         quo_reg  [N];
    bsc_pkg::side_t       side_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[N-2:0], req.valid};
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [N-1:0]   pr, pd, ps, pq;
        bsc_pkg::side_t pside;
        logic [N:0]     trial;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign pr    = '0;
            assign pd    = req.dividend;
            assign ps    = req.divisor;
            assign pq    = '0;
            assign pside = req.side;
        end
        else
        begin : g_next
            assign pr    = rem_reg[k-1];
            assign pd    = dvd_reg[k-1];
            assign ps    = dvs_reg[k-1];
            assign pq    = quo_reg[k-1];
            assign pside = side_reg[k-1];
        end

        assign trial = {pr, pd[N-1]};
        assign ge    = (trial >= {1'b0, ps});

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= ge ? N'(trial - {1'b0, ps}) : N'(trial);
            dvd_reg[k]  <= pd << 1;
            dvs_reg[k]  <= ps;
            quo_reg[k]  <= {pq[N-2:0], ge};
            side_reg[k] <= pside;
        end
    end

    assign rsp.valid    = v_reg[N-1];
    assign rsp.quotient = quo_reg[N-1];
    assign rsp.side     = side_reg[N-1];

endmodule

// ===== design/bsc_back.sv =====
// Back pipeline: quotient scaling and the second-order pressure correction.
// Depends on bsc_pkg.
module bsc_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bsc_pkg::div_rsp_t            rsp,
    input  bsc_pkg::cal_t                cal,
    output logic                         out_valid,
    output logic [bsc_pkg::DATA_W-1:0]   out_temp,
    output logic [bsc_pkg::DATA_W-1:0]   out_press,
    output logic                         out_zero
);

    localparam int W = bsc_pkg::DATA_W;

    logic [bsc_pkg::BACK_STAGES:1] v_reg;
    logic [W-1:0] p1_reg, p2_reg, p3_reg, e_reg, g0_reg, f0_reg, g_reg, press_reg;
    logic [W-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic         z1_reg, z2_reg, z3_reg, z4_reg;
    logic [W-1:0] pq, fsum;

    assign pq   = rsp.side.post2 ? (rsp.quotient << 1) : rsp.quotient;
    assign fsum = bsc_pkg::sra(f0_reg, 12) + g_reg + cal.p7;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[bsc_pkg::BACK_STAGES-1:1], rsp.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg    <= pq;
        t1_reg    <= rsp.side.temp;
        z1_reg    <= rsp.side.zero;
        e_reg     <= (p1_reg >> 3) * (p1_reg >> 3);
        g0_reg    <= (p1_reg >> 2) * cal.p8;
        p2_reg    <= p1_reg;
        t2_reg    <= t1_reg;
        z2_reg    <= z1_reg;
        f0_reg    <= cal.p9 * (e_reg >> 13);
        g_reg     <= bsc_pkg::sra(g0_reg, 13);
        p3_reg    <= p2_reg;
        t3_reg    <= t2_reg;
        z3_reg    <= z2_reg;
        press_reg <= z3_reg ? '0 : p3_reg + bsc_pkg::sra(fsum, 4);
        t4_reg    <= t3_reg;
        z4_reg    <= z3_reg;
    end

    assign out_valid = v_reg[bsc_pkg::BACK_STAGES];
    assign out_temp  = t4_reg;
    assign out_press = press_reg;
    assign out_zero  = z4_reg;

endmodule

// ===== design/baro_sensor_compensation_core.sv =====
// Top level of the barometric compensation core: calibration registers and pipeline.
// Depends on bsc_pkg, bsc_front, bsc_div and bsc_back.
//
//  channel   | ports                                            | handshake
//  ----------+--------------------------------------------------+------------------------
//  request   | temp_sample, press_sample                        | start && !busy
//  result    | temperature_centi, pressure_pa, divisor_zero     | done, one cycle
//  config    | cfg_index, cfg_data                              | cfg_we
//
// A request enters every cycle; busy stays low. The result passes through 11 front stages,
// 32 divider stages (one quotient bit each) and 4 back stages.
// Reset clears the calibration registers and the valid bits of every stage.
// The result strobe lasts one cycle and cannot be held off.
module baro_sensor_compensation_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bsc_pkg::RAW_W-1:0]         temp_sample,
    input  logic [bsc_pkg::RAW_W-1:0]         press_sample,
    output logic                              done,
    output logic signed [bsc_pkg::DATA_W-1:0] temperature_centi,
    output logic [bsc_pkg::DATA_W-1:0]        pressure_pa,
    output logic                              divisor_zero,
    input  logic                              cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bsc_pkg::CFG_W-1:0]         cfg_data
);

    logic [47:0]        cal_temp_reg;
    logic [63:0]        cal_press_a_reg;
    logic [63:0]        cal_press_b_reg;
    logic [15:0]        cal_p9_reg;
    bsc_pkg::cal_t      cal;
    bsc_pkg::div_req_t  req;
    bsc_pkg::div_rsp_t  rsp;
    logic [bsc_pkg::DATA_W-1:0] temp_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg    <= '0;
            cal_press_a_reg <= '0;
            cal_press_b_reg <= '0;
            cal_p9_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bsc_pkg::REG_CAL_TEMP:    cal_temp_reg    <= cfg_data[47:0];
                bsc_pkg::REG_CAL_PRESS_A: cal_press_a_reg <= cfg_data;
                bsc_pkg::REG_CAL_PRESS_B: cal_press_b_reg <= cfg_data;
                bsc_pkg::REG_CAL_P9:      cal_p9_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cal.t1 = {16'd0, cal_temp_reg[15:0]};
    assign cal.t2 = {{16{cal_temp_reg[31]}}, cal_temp_reg[31:16]};
    assign cal.t3 = {{16{cal_temp_reg[47]}}, cal_temp_reg[47:32]};
    assign cal.p1 = {16'd0, cal_press_a_reg[15:0]};
    assign cal.p2 = {{16{cal_press_a_reg[31]}}, cal_press_a_reg[31:16]};
    assign cal.p3 = {{16{cal_press_a_reg[47]}}, cal_press_a_reg[47:32]};
    assign cal.p4 = {{16{cal_press_a_reg[63]}}, cal_press_a_reg[63:48]};
    assign cal.p5 = {{16{cal_press_b_reg[15]}}, cal_press_b_reg[15:0]};
    assign cal.p6 = {{16{cal_press_b_reg[31]}}, cal_press_b_reg[31:16]};
    assign cal.p7 = {{16{cal_press_b_reg[47]}}, cal_press_b_reg[47:32]};
    assign cal.p8 = {{16{cal_press_b_reg[63]}}, cal_press_b_reg[63:48]};
    assign cal.p9 = {{16{cal_p9_reg[15]}}, cal_p9_reg};

    assign busy = 1'b0;

    bsc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .adc_t    (temp_sample),
        .adc_p    (press_sample),
        .cal      (cal),
        .req      (req)
    );

    bsc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    bsc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rsp       (rsp),
        .cal       (cal),
        .out_valid (done),
        .out_temp  (temp_out),
        .out_press (pressure_pa),
        .out_zero  (divisor_zero)
    );

    assign temperature_centi = $signed(temp_out);

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, bsc_pkg::LATENCY))
        else $error("result without matching request");

    a_zero_press: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divisor_zero) |-> (pressure_pa == '0))
        else $error("zero divisor but nonzero pressure");

    a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> $past(req.valid, bsc_pkg::DATA_W))
        else $error("divider valid misaligned");

endmodule

// ===== tb/baro_sensor_compensation_core_tb.sv =====
// Self-checking testbench for baro_sensor_compensation_core: directed table, then random
// calibration phases with random sample pairs; results checked vs. table or local model.
// Depends on bsc_pkg and the core RTL.
module baro_sensor_compensation_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [DATA_W-1:0] temp;
        logic [DATA_W-1:0] press;
        logic              flag;
    } reading_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_REQ, ROW_REQ_CHK} row_kind_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]   data;
        logic [RAW_W-1:0]   rt;
        logic [RAW_W-1:0]   rp;
        reading_t           want;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [RAW_W-1:0]     temp_sample = '0;
    logic [RAW_W-1:0]     press_sample = '0;
    logic                 done;
    logic signed [DATA_W-1:0] temperature_centi;
    logic [DATA_W-1:0]    pressure_pa;
    logic                 divisor_zero;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    logic [47:0] sh_cal_temp = '0;
    logic [63:0] sh_cal_press_a = '0;
    logic [63:0] sh_cal_press_b = '0;
    logic [15:0] sh_cal_p9 = '0;

    reading_t pending_q[$];
    row_t     dir_rows[$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       quiet_phase = 0;

    baro_sensor_compensation_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .temp_sample(temp_sample), .press_sample(press_sample),
        .done(done), .temperature_centi(temperature_centi), .pressure_pa(pressure_pa),
        .divisor_zero(divisor_zero),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        logic signed [31:0] s;
        s = x;
        return s >>> n;
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic reading_t compensate(input logic [RAW_W-1:0] rt,
                                            input logic [RAW_W-1:0] rp);
        logic [31:0] adc, adp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, d, b, tf, v1, v2, q, p, e, f, g;
        reading_t r;
        adc = {12'b0, rt};
        adp = {12'b0, rp};
        t1 = {16'b0, sh_cal_temp[15:0]};
        t2 = sx16(sh_cal_temp[31:16]);
        t3 = sx16(sh_cal_temp[47:32]);
        p1 = {16'b0, sh_cal_press_a[15:0]};
        p2 = sx16(sh_cal_press_a[31:16]);
        p3 = sx16(sh_cal_press_a[47:32]);
        p4 = sx16(sh_cal_press_a[63:48]);
        p5 = sx16(sh_cal_press_b[15:0]);
        p6 = sx16(sh_cal_press_b[31:16]);
        p7 = sx16(sh_cal_press_b[47:32]);
        p8 = sx16(sh_cal_press_b[63:48]);
        p9 = sx16(sh_cal_p9);
        a = asr(((adc >> 3) - (t1 << 1)) * t2, 11);
        d = (adc >> 4) - t1;
        b = asr(asr(d * d, 12) * t3, 14);
        tf = a + b;
        r.temp = asr(tf * 32'd5 + 32'd128, 8);
        v1 = asr(tf, 1) - 32'd64000;
        q = asr(v1, 2);
        v2 = asr(q * q, 11) * p6;
        v2 = v2 + ((v1 * p5) << 1);
        v2 = asr(v2, 2) + (p4 << 16);
        v1 = asr(asr(p3 * asr(q * q, 13), 3) + asr(p2 * v1, 1), 18);
        v1 = asr((32'd32768 + v1) * p1, 15);
        if (v1 == 32'd0) begin
            r.press = '0;
            r.flag = 1'b1;
        end
        else begin
            p = ((32'd1048576 - adp) - asr(v2, 12)) * 32'd3125;
            if (p < 32'h80000000)
                p = (p << 1) / v1;
            else
                p = (p / v1) * 32'd2;
            e = (p >> 3) * (p >> 3);
            f = asr(p9 * (e >> 13), 12);
            g = asr((p >> 2) * p8, 13);
            r.press = p + asr(f + g + p7, 4);
            r.flag = 1'b0;
        end
        return r;
    endfunction

    task automatic wait_idle();
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CAL_TEMP:    sh_cal_temp = data[47:0];
            REG_CAL_PRESS_A: sh_cal_press_a = data;
            REG_CAL_PRESS_B: sh_cal_press_b = data;
            REG_CAL_P9:      sh_cal_p9 = data[15:0];
        endcase
        @(posedge clk);
    endtask

    // start stays high from one request to the next unless a gap is drawn
    task automatic send_request(input logic [RAW_W-1:0] rt, input logic [RAW_W-1:0] rp,
                                input bit typed, input reading_t want);
        int gap;
        int sel;
        sel = $urandom_range(0, 99);
        if (quiet_phase || sel < 50)
            gap = 0;
        else if (sel < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        temp_sample <= rt;
        press_sample <= rp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_q.push_back(typed ? want : compensate(rt, rp));
    endtask

    function automatic logic [RAW_W-1:0] rand_raw();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return RAW_W'($urandom_range(350000, 650000));
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk) begin
        reading_t w;
        if (rst_n && done) begin
            if (pending_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("Unexpected result: temp %0d press %0d flag %0b",
                             temperature_centi, pressure_pa, divisor_zero);
            end
            else begin
                w = pending_q.pop_front();
                if (temperature_centi !== w.temp || pressure_pa !== w.press ||
                    divisor_zero !== w.flag) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Mismatch: exp temp %0d press %0d flag %0b, got %0d %0d %0b",
                                 $signed(w.temp), w.press, w.flag,
                                 temperature_centi, pressure_pa, divisor_zero);
                end
            end
        end
    end

    initial begin
        row_t r;
        logic [63:0] d;
        int mode;
        // zero calibration: temperature 0, divisor zero
        dir_rows.push_back({ROW_REQ_CHK, REG_CAL_TEMP, 64'd0, 20'h00000, 20'h00000,
                            {32'd0, 32'd0, 1'b1}});
        dir_rows.push_back({ROW_REQ_CHK, REG_CAL_TEMP, 64'd0, 20'hFFFFF, 20'hFFFFF,
                            {32'd0, 32'd0, 1'b1}});
        dir_rows.push_back({ROW_REQ_CHK, REG_CAL_TEMP, 64'd0, 20'h80000, 20'h00001,
                            {32'd0, 32'd0, 1'b1}});
        dir_rows.push_back({ROW_REQ_CHK, REG_CAL_TEMP, 64'd0, 20'h00001, 20'h80000,
                            {32'd0, 32'd0, 1'b1}});
        // typical calibration
        dir_rows.push_back({ROW_CFG, REG_CAL_TEMP, 64'hFFFF_FC18_6743_6B70, 40'd0, 65'd0});
        dir_rows.push_back({ROW_CFG, REG_CAL_PRESS_A, 64'h0B27_0BD0_D643_8E7D, 40'd0, 65'd0});
        dir_rows.push_back({ROW_CFG, REG_CAL_PRESS_B, 64'hC6F8_3C8C_FFF9_008C, 40'd0, 65'd0});
        dir_rows.push_back({ROW_CFG, REG_CAL_P9, 64'hABCD_0000_0000_1770, 40'd0, 65'd0});
        dir_rows.push_back({ROW_REQ, REG_CAL_TEMP, 64'd0, 20'd519888, 20'd415148, 65'd0});
        dir_rows.push_back({ROW_REQ, REG_CAL_TEMP, 64'd0, 20'h00000, 20'h00000, 65'd0});
        dir_rows.push_back({ROW_REQ, REG_CAL_TEMP, 64'd0, 20'hFFFFF, 20'hFFFFF, 65'd0});
        dir_rows.push_back({ROW_REQ, REG_CAL_TEMP, 64'd0, 20'h00000, 20'hFFFFF, 65'd0});
        dir_rows.push_back({ROW_REQ, REG_CAL_TEMP, 64'd0, 20'hFFFFF, 20'h00000, 65'd0});
        // zero P1 with live temperature path
        dir_rows.push_back({ROW_CFG, REG_CAL_PRESS_A, 64'h0B27_0BD0_D643_0000, 40'd0, 65'd0});
        dir_rows.push_back({ROW_REQ, REG_CAL_TEMP, 64'd0, 20'd519888, 20'd415148, 65'd0});
        // all-ones calibration
        dir_rows.push_back({ROW_CFG, REG_CAL_TEMP, 64'hFFFF_FFFF_FFFF_FFFF, 40'd0, 65'd0});
        dir_rows.push_back({ROW_CFG, REG_CAL_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF, 40'd0, 65'd0});
        dir_rows.push_back({ROW_CFG, REG_CAL_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF, 40'd0, 65'd0});
        dir_rows.push_back({ROW_CFG, REG_CAL_P9, 64'hFFFF_FFFF_FFFF_FFFF, 40'd0, 65'd0});
        dir_rows.push_back({ROW_REQ, REG_CAL_TEMP, 64'd0, 20'h00000, 20'h00000, 65'd0});
        dir_rows.push_back({ROW_REQ, REG_CAL_TEMP, 64'd0, 20'hFFFFF, 20'hFFFFF, 65'd0});
        dir_rows.push_back({ROW_REQ, REG_CAL_TEMP, 64'd0, 20'h55555, 20'hAAAAA, 65'd0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.kind == ROW_CFG) begin
                start <= 1'b0;
                wait_idle();
                write_cal(r.idx, r.data);
            end
            else
                send_request(r.rt, r.rp, r.kind == ROW_REQ_CHK, r.want);
        end

        for (int ph = 0; ph < 10; ph++) begin
            start <= 1'b0;
            wait_idle();
            quiet_phase = (ph % 4 == 3);
            mode = $urandom_range(0, 2);
            for (int k = 0; k < 4; k++) begin
                d = {$urandom, $urandom};
                if (mode == 0) begin
                    // near-typical values keep the pressure formula in range
                    case (k)
                        0: d[47:0] = {16'hFC18 + 16'($urandom_range(0, 200)),
                                      16'h6743 + 16'($urandom_range(0, 2000)),
                                      16'h6B70 + 16'($urandom_range(0, 2000))};
                        1: d = {16'h0B27, 16'h0BD0, 16'hD643,
                                16'h8E7D + 16'($urandom_range(0, 4000))};
                        2: d = {16'hC6F8, 16'h3C8C, 16'hFFF9, 16'h008C};
                        default: d[15:0] = 16'h1770 + 16'($urandom_range(0, 500));
                    endcase
                end
                else if (mode == 2)
                    d = {rand_word(), rand_word(), rand_word(), rand_word()};
                write_cal(REG_CAL_TEMP + CFG_IDX_W'(k), d);
            end
            for (int n = 0; n < 200; n++)
                send_request(rand_raw(), rand_raw(), 1'b0, '0);
        end

        start <= 1'b0;
        wait_idle();
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
